// File: design/ptd_pkg.sv
`default_nettype none
package ptd_pkg;

    // Default width of the tested value.
    localparam int unsigned PtdValueBits = 32;

endpackage
`default_nettype wire

// File: design/prime_trial_division.sv
// Trial-division primality tester.
// Input channel s_valid/s_ready carries s_value, an unsigned VALUE_BITS-bit
// number. Result channel m_valid/m_ready carries m_is_prime_flag, which is 1
// when the value is prime. Every input transaction yields one result
// transaction, in order.
// Zero, one, two and even values are decided at once, with no division:
// m_valid rises after acceptance once the output register is free. Odd
// values above two are tested against the odd divisors 3, 5, 7, ... with a
// bit-serial restoring divider; its quotient also gives the bound test
// divisor <= value / divisor. The number of divisors tried, k, reaches
// roughly 2^(VALUE_BITS/2 - 1) for a large prime.
// One value is worked on at a time; s_ready is high only while the tester is
// idle. A finished result sits in the output register, so the next value may
// be accepted while the receiver stalls; its result then waits until the
// output register is free.
// Reset (aresetn low, synchronous) abandons any test in progress and drops a
// pending result. No state carries over between values.
`default_nettype none
module prime_trial_division
    import ptd_pkg::*;
#(
    parameter int unsigned VALUE_BITS = PtdValueBits
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [VALUE_BITS-1:0] s_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_is_prime_flag
);

    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StStart  = 2'd1;
    localparam logic [1:0] StDiv    = 2'd2;
    localparam logic [1:0] StResult = 2'd3;

    localparam logic [VALUE_BITS-1:0] ValTwo   = VALUE_BITS'(2);
    localparam logic [VALUE_BITS-1:0] ValThree = VALUE_BITS'(3);

    logic [1:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] v_reg;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic                  res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_flag_reg, m_flag_next;

    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [VALUE_BITS-1:0] div_rem;

    logic                  s_fire;
    logic                  out_free;

    ptd_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_quot),
        .remainder(div_rem)
    );

    assign s_ready   = (state_reg == StIdle);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == StStart);

    always_comb begin
        state_next   = state_reg;
        d_next       = d_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_flag_next  = m_flag_reg;
        case (state_reg)
            StIdle: begin
                if (s_fire) begin
                    d_next = ValThree;
                    if (s_value == ValTwo) begin
                        res_next   = 1'b1;
                        state_next = StResult;
                    end else if (s_value < ValTwo || !s_value[0]) begin
                        res_next   = 1'b0;
                        state_next = StResult;
                    end else begin
                        state_next = StStart;
                    end
                end
            end
            StStart: begin
                state_next = StDiv;
            end
            StDiv: begin
                if (div_done) begin
                    // Past the square root with no factor found: prime.
                    if (d_reg > div_quot) begin
                        res_next   = 1'b1;
                        state_next = StResult;
                    end else if (div_rem == '0) begin
                        res_next   = 1'b0;
                        state_next = StResult;
                    end else begin
                        d_next     = d_reg + ValTwo;
                        state_next = StStart;
                    end
                end
            end
            StResult: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_flag_next  = res_reg;
                    state_next   = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            v_reg <= s_value;
        end
        d_reg      <= d_next;
        res_reg    <= res_next;
        m_flag_reg <= m_flag_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_is_prime_flag = m_flag_reg;

endmodule
`default_nettype wire

// File: design/ptd_div.sv
`default_nettype none
module ptd_div
    import ptd_pkg::*;
#(
    parameter int unsigned VALUE_BITS = PtdValueBits
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [VALUE_BITS-1:0] divisor,
    output logic                       done,
    output logic [VALUE_BITS-1:0]      quotient,
    output logic [VALUE_BITS-1:0]      remainder
);

    localparam int unsigned CntBits = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CntBits-1:0]    cnt_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    // Holds the dividend, which shifts out at the top while quotient bits
    // shift in at the bottom.
    logic [VALUE_BITS-1:0] dq_reg;

    logic [VALUE_BITS:0]   partial;
    logic [VALUE_BITS:0]   diff;
    logic                  ge;

    // One restoring step per cycle; the divisor is held steady by the caller.
    assign partial = {rem_reg, dq_reg[VALUE_BITS-1]};
    assign ge      = partial >= {1'b0, divisor};
    assign diff    = partial - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntBits'(VALUE_BITS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CntBits'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dq_reg  <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[VALUE_BITS-1:0] : partial[VALUE_BITS-1:0];
            dq_reg  <= {dq_reg[VALUE_BITS-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire
